// ===== sv/fste_pkg.sv =====
package fste_pkg;

  localparam int NORM_W   = 16;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ROOT_W   = 32;
  localparam int NUM_W    = 46;
  localparam int NORM_EXP = 29;
  localparam int FRAC_W   = 15;
  localparam int QUO_W    = 16;
  localparam int SQRT_ITERS = 32;

  localparam logic [QUO_W-1:0] NORM_MAX = 16'd32767;

endpackage

// ===== sv/fste_tri_if.sv =====
interface fste_tri_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax, ay, az;
  logic signed [COORD_BITS-1:0] bx, by, bz;
  logic signed [COORD_BITS-1:0] cx, cy, cz;

  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

// ===== sv/fste_vtx_if.sv =====
interface fste_vtx_if #(
  parameter int COORD_BITS = 24,
  parameter int INDEX_BITS = 16
);
  import fste_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] px, py, pz;
  logic signed [NORM_W-1:0]     norm_x, norm_y, norm_z;
  logic        [INDEX_BITS-1:0] vertex_index;
  logic                         last_vertex;

  modport source (output valid, px, py, pz, norm_x, norm_y, norm_z, vertex_index,
                  last_vertex, input ready);
  modport sink   (input valid, px, py, pz, norm_x, norm_y, norm_z, vertex_index,
                  last_vertex, output ready);
endinterface

// ===== sv/flat_shaded_triangle_emitter.sv =====
// Channel  | Dir | Carries
// tri_in   | in  | one triangle: vertices a, b, c (ax..cz)
// vtx_out  | out | three vertices per triangle with shared Q1.15 normal, index, last flag
//
// One triangle runs the cross product on the shared multiplier, then the magnitude, the
// normalizing shifts, three squares, the square root, a step that latches the root and
// three divisions, then three output requests.
// A degenerate triangle returns to idle from its first normalize step.
// tri_in.ready is high only while idle; vtx_out stalls hold the current vertex.
// rst is synchronous and clears state and the vertex index.
module flat_shaded_triangle_emitter #(
  parameter int COORD_BITS = 24,
  parameter int INDEX_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  fste_tri_if.sink   tri_in,
  fste_vtx_if.source vtx_out
);
  import fste_pkg::*;

  localparam int PRE_SHIFT = (COORD_BITS > 24) ? COORD_BITS - 24 : 0;
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int DW        = COORD_BITS - PRE_SHIFT + 1;
  localparam int NW        = 2 * DW + 1;
  localparam int MAGW      = (2 * DW > 31) ? 2 * DW : 31;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_ABS, S_NORM, S_SQMUL, S_SQACC, S_SQRT, S_ROOT, S_DIVLD, S_DIV,
    S_EMIT
  } state_t;

  state_t state;

  logic signed [COORD_BITS-1:0] vx [3];
  logic signed [COORD_BITS-1:0] vy [3];
  logic signed [COORD_BITS-1:0] vz [3];
  logic signed [DW-1:0]         u [3];
  logic signed [DW-1:0]         v [3];
  logic signed [NW-1:0]         n [3];
  logic        [MAGW-1:0]       m [3];
  logic                         neg [3];
  logic        [2:0]            step;
  logic signed [PROD_W-1:0]     prod;
  logic        [PROD_W-1:0]     s_rem, s_res, s_bit;
  logic        [4:0]            iter;
  logic        [ROOT_W-1:0]     r;
  logic        [ROOT_W-1:0]     d_rem;
  logic        [QUO_W-1:0]      d_lo;
  logic        [QUO_W-1:0]      d_quo;
  logic        [3:0]            d_cnt;
  logic        [QUO_W-1:0]      nq [3];
  logic        [1:0]            comp;
  logic        [1:0]            k;
  logic        [INDEX_BITS-1:0] idx;

  // truncate an edge difference toward zero by PRE_SHIFT bits
  function automatic logic signed [DW-1:0] shrink(input logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] mag;
    mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    mag = mag >> PRE_SHIFT;
    return d[DIFF_W-1] ? -$signed(DW'(mag)) : $signed(DW'(mag));
  endfunction

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic                    acc_sub;
  logic [1:0]              acc_sel;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    acc_sub = step[0];
    acc_sel = 2'(step >> 1);
    if (state == S_SQMUL) begin
      mul_a = $signed({1'b0, m[step[1:0]][MUL_W-2:0]});
      mul_b = mul_a;
    end else begin
      unique case (step)
        3'd0: begin mul_a = MUL_W'(u[1]); mul_b = MUL_W'(v[2]); end
        3'd1: begin mul_a = MUL_W'(u[2]); mul_b = MUL_W'(v[1]); end
        3'd2: begin mul_a = MUL_W'(u[2]); mul_b = MUL_W'(v[0]); end
        3'd3: begin mul_a = MUL_W'(u[0]); mul_b = MUL_W'(v[2]); end
        3'd4: begin mul_a = MUL_W'(u[0]); mul_b = MUL_W'(v[1]); end
        default: begin mul_a = MUL_W'(u[1]); mul_b = MUL_W'(v[0]); end
      endcase
    end
  end

  logic [MAGW-1:0] top;
  always_comb begin
    top = m[0];
    if (m[1] > top) top = m[1];
    if (m[2] > top) top = m[2];
  end

  logic [PROD_W-1:0] s_try;
  assign s_try = s_res + s_bit;

  logic [ROOT_W-1:0] d_sh;
  logic              d_ge;
  assign d_sh = {d_rem[ROOT_W-2:0], d_lo[QUO_W-1]};
  assign d_ge = d_sh >= r;

  logic [NUM_W-1:0] num;
  assign num = {m[comp][NORM_EXP:0], FRAC_W'(0)} + NUM_W'(r >> 1);

  logic [QUO_W-1:0] q_final, q_sat;
  assign q_final = {d_quo[QUO_W-2:0], d_ge};
  assign q_sat   = (q_final > NORM_MAX) ? NORM_MAX : q_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      step  <= '0;
      k     <= '0;
      comp  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (tri_in.valid) begin
            vx[0] <= tri_in.ax; vy[0] <= tri_in.ay; vz[0] <= tri_in.az;
            vx[1] <= tri_in.bx; vy[1] <= tri_in.by; vz[1] <= tri_in.bz;
            vx[2] <= tri_in.cx; vy[2] <= tri_in.cy; vz[2] <= tri_in.cz;
            u[0] <= shrink(DIFF_W'(tri_in.bx) - DIFF_W'(tri_in.ax));
            u[1] <= shrink(DIFF_W'(tri_in.by) - DIFF_W'(tri_in.ay));
            u[2] <= shrink(DIFF_W'(tri_in.bz) - DIFF_W'(tri_in.az));
            v[0] <= shrink(DIFF_W'(tri_in.cx) - DIFF_W'(tri_in.ax));
            v[1] <= shrink(DIFF_W'(tri_in.cy) - DIFF_W'(tri_in.ay));
            v[2] <= shrink(DIFF_W'(tri_in.cz) - DIFF_W'(tri_in.az));
            for (int i = 0; i < 3; i++) n[i] <= '0;
            step  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_ACC;
        end
        S_ACC: begin
          if (acc_sub) n[acc_sel] <= n[acc_sel] - NW'(prod);
          else         n[acc_sel] <= n[acc_sel] + NW'(prod);
          if (step == 3'd5) begin
            state <= S_ABS;
          end else begin
            step  <= step + 3'd1;
            state <= S_MUL;
          end
        end
        S_ABS: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= n[i][NW-1];
            m[i]   <= MAGW'($unsigned(n[i][NW-1] ? -n[i] : n[i]));
          end
          state <= S_NORM;
        end
        S_NORM: begin
          priority if (top == '0) begin
            state <= S_IDLE;
          end else if ((top >> (NORM_EXP + 5)) != '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 4;
          end else if ((top >> (NORM_EXP + 1)) != '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if ((top >> (NORM_EXP - 3)) == '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 4;
          end else if ((top >> NORM_EXP) == '0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            s_rem <= '0;
            step  <= '0;
            state <= S_SQMUL;
          end
        end
        S_SQMUL: begin
          prod  <= mul_a * mul_b;
          state <= S_SQACC;
        end
        S_SQACC: begin
          s_rem <= s_rem + $unsigned(prod);
          if (step == 3'd2) begin
            s_res <= '0;
            s_bit <= PROD_W'(1) << (PROD_W - 2);
            iter  <= '0;
            state <= S_SQRT;
          end else begin
            step  <= step + 3'd1;
            state <= S_SQMUL;
          end
        end
        S_SQRT: begin
          if (s_rem >= s_try) begin
            s_rem <= s_rem - s_try;
            s_res <= (s_res >> 1) + s_bit;
          end else begin
            s_res <= s_res >> 1;
          end
          s_bit <= s_bit >> 2;
          iter  <= iter + 5'd1;
          if (iter == 5'(SQRT_ITERS - 1)) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (s_res[ROOT_W-1:0] != '0) r <= s_res[ROOT_W-1:0];
          else                         r <= ROOT_W'(1);
          comp  <= '0;
          state <= S_DIVLD;
        end
        S_DIVLD: begin
          // high part of the numerator is already below r, so 16 steps give the quotient
          d_rem <= ROOT_W'(num >> QUO_W);
          d_lo  <= num[QUO_W-1:0];
          d_quo <= '0;
          d_cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          d_rem <= d_ge ? d_sh - r : d_sh;
          d_lo  <= d_lo << 1;
          d_quo <= q_final;
          d_cnt <= d_cnt + 4'd1;
          if (d_cnt == 4'd15) begin
            nq[comp] <= neg[comp] ? QUO_W'(-q_sat) : q_sat;
            if (comp == 2'd2) begin
              k     <= '0;
              state <= S_EMIT;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_DIVLD;
            end
          end
        end
        S_EMIT: begin
          if (vtx_out.ready) begin
            idx <= idx + INDEX_BITS'(1);
            if (k == 2'd2) begin
              k     <= '0;
              state <= S_IDLE;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign tri_in.ready = (state == S_IDLE);

  assign vtx_out.valid        = (state == S_EMIT);
  assign vtx_out.px           = vx[k];
  assign vtx_out.py           = vy[k];
  assign vtx_out.pz           = vz[k];
  assign vtx_out.norm_x       = $signed(nq[0]);
  assign vtx_out.norm_y       = $signed(nq[1]);
  assign vtx_out.norm_z       = $signed(nq[2]);
  assign vtx_out.vertex_index = idx;
  assign vtx_out.last_vertex  = (k == 2'd2);

  assert property (@(posedge clk) disable iff (rst) vtx_out.valid |-> !tri_in.ready)
    else $error("output request while accepting a triangle");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (r[ROOT_W-1:NORM_EXP] != '0))
    else $error("root below normalized range");
  assert property (@(posedge clk) disable iff (rst)
    (vtx_out.valid && vtx_out.ready && vtx_out.last_vertex) |=> state == S_IDLE)
    else $error("no return to idle after last vertex");
  assert property (@(posedge clk) disable iff (rst)
    vtx_out.valid |-> (vtx_out.norm_x != 16'sh8000 && vtx_out.norm_y != 16'sh8000
                       && vtx_out.norm_z != 16'sh8000))
    else $error("normal outside saturated range");

endmodule
